// ===== rtl/core/head_pose_from_landmarks_assert.svh =====
// assertion macros for the head pose block and its checker
// no dependencies; included by the checker file only
`ifndef HEAD_POSE_FROM_LANDMARKS_ASSERT_SVH
`define HEAD_POSE_FROM_LANDMARKS_ASSERT_SVH

// same-cycle implication
`define HPFL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("head pose assertion failed");

// next-cycle implication
`define HPFL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("head pose assertion failed");

`endif

// ===== rtl/core/hpfl_pkg.sv =====
// shared types and constants for the head pose block
// no dependencies; used by the top level and the checker
`default_nettype none
package hpfl_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned IN_DATA_W = 9 * COORD_W;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOSE_RATIO = 8'd1;

  localparam logic [14:0] THR_RESET   = 15'd1638;
  localparam logic [14:0] RATIO_RESET = 15'd13107;

  localparam logic [17:0] Q14_ONE  = 18'd16384;
  localparam logic [17:0] Q14_TWO  = 18'd32768;
  localparam logic [17:0] Q14_HALF = 18'd8192;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT_INIT, S_SQRT, S_PDEN,
    S_DINIT, S_DIV, S_DPOST, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_YAW, PH_PITCH, PH_ROLL
  } phase_t;

endpackage
`default_nettype wire

// ===== rtl/core/head_pose_from_landmarks.sv =====
// head pose (pitch, yaw, roll) from facial landmarks, sequential core
// depends on hpfl_pkg; one shared multiplier and one shared subtractor
//
//  channel | dir | handshake           | content
//  s_*     | in  | s_tvalid / s_tready | landmarks (tdata), complete flag (tuser)
//  m_*     | out | m_tvalid / m_tready | pitch, yaw, roll (tdata), moving (tuser)
//  cfg_*   | in  | cfg_valid/cfg_ready | register index, write data
//
// a result is loaded into the output register before the next item can be taken
// the divisions are skipped when the landmarks are incomplete or the eye distance is zero,
// and the pitch division when nose_ratio is zero; the 25-step square root and three divisions
// (setup, 18 quotient bits, post) all run on one shared 60-bit subtractor
// rst is synchronous; it clears the sequencer, output valid and previous pose, and presets the registers
// input is taken only in idle; a finished result waits in the output register
// while the next item is accepted, and stalls the core only when it is still untaken
`default_nettype none
module head_pose_from_landmarks (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // left_eye_x, left_eye_y, right_eye_x, right_eye_y, nose_y,
  // mouth_left_x, mouth_right_x, face_left_x, face_right_x
  input  wire  [hpfl_pkg::IN_DATA_W-1:0]      s_tdata,
  // landmarks_complete
  input  wire                                 s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // pitch [15:0], yaw [31:16], roll [46:32], zero pad [47]
  output logic [hpfl_pkg::OUT_DATA_W-1:0]     m_tdata,
  // moving flag
  output logic                                m_tuser,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [hpfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [hpfl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hpfl_pkg::*;

  state_t state, state_next;
  phase_t phase;

  logic [4:0]  cnt;
  logic        complete;
  logic [15:0] adx, ady;
  logic        dy_pos;
  logic [16:0] dmag, mmag;
  logic        drop_neg, moff_neg;
  logic [32:0] sq;
  logic [53:0] acc;
  logic [48:0] rt, sbit;
  logic [58:0] dreg;
  logic [17:0] q;
  logic [24:0] e;
  logic [39:0] pden;
  logic [15:0] pitch_r, yaw_r;
  logic [14:0] roll_r;
  logic [15:0] prev_pitch, prev_yaw;
  logic [14:0] prev_roll;
  logic [14:0] thr, ratio;

  // input unpacking
  logic [15:0] lx, ly, rx, ry, ny, mlx, mrx, flx, frx;
  assign lx  = s_tdata[15:0];
  assign ly  = s_tdata[31:16];
  assign rx  = s_tdata[47:32];
  assign ry  = s_tdata[63:48];
  assign ny  = s_tdata[79:64];
  assign mlx = s_tdata[95:80];
  assign mrx = s_tdata[111:96];
  assign flx = s_tdata[127:112];
  assign frx = s_tdata[143:128];

  // nose drop and mouth offset, both doubled, signed
  logic signed [18:0] drop2, moff2;
  assign drop2 = $signed({2'b0, ny, 1'b0}) - $signed({3'b0, ly}) - $signed({3'b0, ry});
  assign moff2 = $signed({3'b0, mlx}) + $signed({3'b0, mrx})
               - $signed({3'b0, flx}) - $signed({3'b0, frx});

  // shared multiplier
  logic [24:0] mul_a;
  logic [15:0] mul_b;
  logic [40:0] prod;
  assign prod = 41'(mul_a) * 41'(mul_b);

  // shared subtractor: acc minus operand, borrow says less than
  logic [58:0] sub_b;
  logic [59:0] diff;
  logic        ge;
  assign diff = {6'b0, acc} - {1'b0, sub_b};
  assign ge   = ~diff[59];

  // operand selection and handshake outputs
  always_comb begin
    s_tready  = (state == S_IDLE);
    cfg_ready = 1'b1;
    mul_a     = 25'(adx);
    mul_b     = adx;
    sub_b     = dreg;
    case (state)
      S_SQY: begin
        mul_a = 25'(ady);
        mul_b = ady;
      end
      S_PDEN: begin
        mul_a = rt[24:0];
        mul_b = {1'b0, ratio};
      end
      S_SQRT: begin
        sub_b = {10'b0, rt | sbit};
      end
      default: begin
      end
    endcase
  end

  // next state
  logic out_free;
  assign out_free = ~m_tvalid | m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (s_tvalid) state_next = S_SQX;
      S_SQX:       state_next = S_SQY;
      S_SQY:       state_next = S_SQRT_INIT;
      S_SQRT_INIT: state_next = S_SQRT;
      S_SQRT:      if (cnt == 5'd0) state_next = S_PDEN;
      S_PDEN: begin
        if (!complete || rt == 49'd0) state_next = S_FIN;
        else state_next = S_DINIT;
      end
      S_DINIT: begin
        // zero expected drop skips the pitch division
        if (!(phase == PH_PITCH && pden == 40'd0)) state_next = S_DIV;
      end
      S_DIV:       if (cnt == 5'd0) state_next = S_DPOST;
      S_DPOST: begin
        if (phase == PH_ROLL) state_next = S_FIN;
        else state_next = S_DINIT;
      end
      S_FIN:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // movement test against the previous pose
  logic [16:0] dp, dyw, dr, ap, ayw, ar;
  logic        moving;
  always_comb begin
    dp  = {pitch_r[15], pitch_r} - {prev_pitch[15], prev_pitch};
    dyw = {yaw_r[15], yaw_r} - {prev_yaw[15], prev_yaw};
    dr  = {{2{roll_r[14]}}, roll_r} - {{2{prev_roll[14]}}, prev_roll};
    ap  = dp[16]  ? -dp  : dp;
    ayw = dyw[16] ? -dyw : dyw;
    ar  = dr[16]  ? -dr  : dr;
    moving = (ap > {2'b0, thr}) || (ayw > {2'b0, thr}) || (ar > {2'b0, thr});
  end

  // clamped magnitudes of the quotient
  logic [17:0] ymag, pmag, rmag;
  assign ymag = (q > Q14_ONE)  ? Q14_ONE  : q;
  assign pmag = (q > Q14_TWO)  ? Q14_TWO  : q;
  assign rmag = (q > Q14_HALF) ? Q14_HALF : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      prev_pitch <= '0;
      prev_yaw   <= '0;
      prev_roll  <= '0;
      thr        <= THR_RESET;
      ratio      <= RATIO_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == CFG_MOVE_THR) thr <= cfg_data[14:0];
        else if (cfg_index == CFG_NOSE_RATIO) ratio <= cfg_data[14:0];
      end
      if (state == S_FIN && out_free) begin
        m_tvalid   <= 1'b1;
        prev_pitch <= pitch_r;
        prev_yaw   <= yaw_r;
        prev_roll  <= roll_r;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          complete <= s_tuser;
          adx      <= (rx >= lx) ? rx - lx : lx - rx;
          ady      <= (ry >= ly) ? ry - ly : ly - ry;
          dy_pos   <= (ry > ly);
          drop_neg <= drop2[18];
          dmag     <= drop2[18] ? 17'(-drop2) : drop2[16:0];
          moff_neg <= moff2[18];
          mmag     <= moff2[18] ? 17'(-moff2) : moff2[16:0];
        end
      end
      S_SQX: sq <= prod[32:0];
      S_SQY: sq <= sq + prod[32:0];
      S_SQRT_INIT: begin
        acc  <= {5'b0, sq, 16'b0};
        rt   <= '0;
        sbit <= {1'b1, 48'b0};
        cnt  <= 5'd24;
      end
      S_SQRT: begin
        if (ge) begin
          acc <= diff[53:0];
          rt  <= (rt >> 1) + sbit;
        end else begin
          rt <= rt >> 1;
        end
        sbit <= sbit >> 2;
        cnt  <= cnt - 5'd1;
      end
      S_PDEN: begin
        e       <= rt[24:0];
        pden    <= prod[39:0];
        phase   <= PH_YAW;
        pitch_r <= '0;
        yaw_r   <= '0;
        roll_r  <= '0;
      end
      S_DINIT: begin
        q   <= '0;
        cnt <= 5'd17;
        case (phase)
          PH_PITCH: begin
            acc  <= {1'b0, dmag, 36'b0} + {14'b0, pden};
            dreg <= {1'b0, pden, 1'b0, 17'b0};
            if (pden == 40'd0) phase <= PH_ROLL;
          end
          PH_ROLL: begin
            acc  <= {15'b0, mmag, 22'b0} + {29'b0, e};
            dreg <= {16'b0, e, 1'b0, 17'b0};
          end
          default: begin
            acc  <= {15'b0, ady, 23'b0} + {29'b0, e};
            dreg <= {16'b0, e, 1'b0, 17'b0};
          end
        endcase
      end
      S_DIV: begin
        if (ge) acc <= diff[53:0];
        q    <= {q[16:0], ge};
        dreg <= dreg >> 1;
        cnt  <= cnt - 5'd1;
      end
      S_DPOST: begin
        case (phase)
          PH_PITCH: begin
            pitch_r <= drop_neg ? -Q14_ONE[15:0] : pmag[15:0] - Q14_ONE[15:0];
            phase   <= PH_ROLL;
          end
          PH_ROLL: roll_r <= moff_neg ? -rmag[14:0] : rmag[14:0];
          default: begin
            yaw_r <= dy_pos ? -ymag[15:0] : ymag[15:0];
            phase <= PH_PITCH;
          end
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          m_tdata <= {1'b0, roll_r, yaw_r, pitch_r};
          m_tuser <= moving;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/hpfl_checker.sv =====
// port-level checker for the head pose block, bound to the top level
// depends on hpfl_pkg and head_pose_from_landmarks_assert.svh
`default_nettype none
`include "head_pose_from_landmarks_assert.svh"
module hpfl_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [hpfl_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import hpfl_pkg::*;

  localparam logic signed [14:0] ROLL_LIM = Q14_HALF[14:0];

  logic signed [14:0] roll_out;
  assign roll_out = $signed(m_tdata[46:32]);

  // a stalled result holds
  `HPFL_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // core is busy right after taking an item
  `HPFL_ASSERT_NXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready)
  // no result can appear the cycle after an item is taken
  `HPFL_ASSERT_NXT(a_no_early, clk, rst, s_tvalid && s_tready, !$rose(m_tvalid))
  // roll stays within plus or minus half
  `HPFL_ASSERT_IMP(a_roll_rng, clk, rst, m_tvalid, roll_out <= ROLL_LIM && roll_out >= -ROLL_LIM)

endmodule

bind head_pose_from_landmarks hpfl_checker u_hpfl_checker (.*);
`default_nettype wire

// ===== test/tb_head_pose_from_landmarks.sv =====
// self-checking testbench for head_pose_from_landmarks
// depends on hpfl_pkg and the block itself; an internal pose predictor,
// randomised stream traffic with stalls and a configuration sweep
`default_nettype none
module tb_head_pose_from_landmarks;
  import hpfl_pkg::*;

  typedef struct {
    logic        complete;
    logic [15:0] lx, ly, rx, ry, ny, mlx, mrx, flx, frx;
  } frame_t;

  typedef struct {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [14:0] roll;
    logic        moving;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  head_pose_from_landmarks DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #2 clk = ~clk;

  // predictor state: registers and last pose
  int unsigned move_thr = 32'(THR_RESET);
  int unsigned nose_rat = 32'(RATIO_RESET);
  int last_pitch = 0, last_yaw = 0, last_roll = 0;

  frame_t frames_to_send[$];
  frame_t frame_on_bus;
  pose_t  poses_due[$];
  int     mismatches = 0;
  bit     long_hold_req = 1'b0;

  // integer square root, bit by bit
  function automatic longint unsigned eye_isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // divide with halves rounded away from zero
  function automatic longint quot_round(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * 2 + den) / (den * 2);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int sat_sym(longint v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return int'(v);
  endfunction

  function automatic int unsigned mag_of(int d);
    return (d < 0) ? -d : d;
  endfunction

  // expected pose for one frame; advances the last-pose state
  function automatic pose_t pose_of_frame(frame_t f);
    pose_t p;
    longint dx, dy, drop2, moff2, q;
    longint unsigned e, pden;
    int pt, yw, rl;
    pt = 0; yw = 0; rl = 0;
    if (f.complete) begin
      dx = longint'(f.rx) - longint'(f.lx);
      dy = longint'(f.ry) - longint'(f.ly);
      e = eye_isqrt((dx * dx + dy * dy) << 16);
      if (e != 0) begin
        drop2 = 2 * longint'(f.ny) - longint'(f.ly) - longint'(f.ry);
        moff2 = longint'(f.mlx) + longint'(f.mrx) - longint'(f.flx) - longint'(f.frx);
        pden = e * nose_rat;
        yw = sat_sym(quot_round(-dy * (64'sd1 <<< 22), e), 16384);
        if (pden != 0) begin
          q = quot_round(drop2 * (64'sd1 <<< 35), pden);
          if (q > 32768) q = 32768;
          if (q < 0) q = 0;
          pt = sat_sym(q - 16384, 16384);
        end
        rl = sat_sym(quot_round(moff2 * (64'sd1 <<< 21), e), 8192);
      end
    end
    p.moving = mag_of(pt - last_pitch) > move_thr || mag_of(yw - last_yaw) > move_thr ||
               mag_of(rl - last_roll) > move_thr;
    last_pitch = pt; last_yaw = yw; last_roll = rl;
    p.pitch = pt[15:0];
    p.yaw   = yw[15:0];
    p.roll  = rl[14:0];
    return p;
  endfunction

  // driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic took;
    took = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (took) poses_due.insert(poses_due.size(), pose_of_frame(frame_on_bus));
      if (!s_tvalid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
          frame_on_bus = frames_to_send.pop_front();
          s_tdata <= {frame_on_bus.frx, frame_on_bus.flx, frame_on_bus.mrx,
                      frame_on_bus.mlx, frame_on_bus.ny, frame_on_bus.ry,
                      frame_on_bus.rx, frame_on_bus.ly, frame_on_bus.lx};
          s_tuser  <= frame_on_bus.complete;
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus a long hold-off on request
  int hold_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_req && hold_left == 0) begin
      hold_left = 2000;
      long_hold_req = 1'b0;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 255) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: compare each result with the oldest expected pose
  always @(posedge clk) begin
    pose_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (poses_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h moving %b", m_tdata, m_tuser);
      end else begin
        want = poses_due.pop_front();
        if (m_tdata[15:0] !== want.pitch || m_tdata[31:16] !== want.yaw ||
            m_tdata[46:32] !== want.roll || m_tuser !== want.moving) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: want p %h y %h r %h m %b, got p %h y %h r %h m %b",
                     want.pitch, want.yaw, want.roll, want.moving,
                     m_tdata[15:0], m_tdata[31:16], m_tdata[46:32], m_tuser);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MOVE_THR) move_thr = val & 32'h7FFF;
    else if (idx == CFG_NOSE_RATIO) nose_rat = val & 32'h7FFF;
  endtask

  // wait for every expected pose, then for the core to settle
  task automatic drain();
    wait (frames_to_send.size() == 0 && !s_tvalid && poses_due.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic void add_frame(frame_t f);
    frames_to_send.insert(frames_to_send.size(), f);
  endfunction

  function automatic logic [15:0] clip16(int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic frame_t odd_frame();
    frame_t f;
    f.complete = 1'($urandom_range(0, 1));
    f.lx = 16'($urandom); f.ly = 16'($urandom); f.rx = 16'($urandom);
    f.ry = 16'($urandom); f.ny = 16'($urandom); f.mlx = 16'($urandom);
    f.mrx = 16'($urandom); f.flx = 16'($urandom); f.frx = 16'($urandom);
    return f;
  endfunction

  // a plausible face with random placement and tilt
  function automatic frame_t face_frame();
    frame_t f;
    int cx, span, midy;
    f.complete = ($urandom_range(0, 19) != 0);
    span = $urandom_range(0, 9) == 0 ? $urandom_range(0, 20) : $urandom_range(300, 9000);
    cx   = $urandom_range(10000, 55000);
    midy = $urandom_range(2000, 60000);
    f.lx  = clip16(cx - span / 2);
    f.rx  = clip16(cx + span / 2);
    f.ly  = clip16(midy + int'($urandom_range(0, span)) - span / 2);
    f.ry  = clip16(midy + int'($urandom_range(0, span)) - span / 2);
    f.ny  = clip16(midy + int'($urandom_range(0, 2 * span)) - span / 4);
    f.mlx = clip16(cx - span / 2 + int'($urandom_range(0, span / 2 + 1)) - span / 4);
    f.mrx = clip16(cx + span / 2 + int'($urandom_range(0, span / 2 + 1)) - span / 4);
    f.flx = clip16(cx - span + int'($urandom_range(0, span / 2 + 1)) - span / 4);
    f.frx = clip16(cx + span + int'($urandom_range(0, span / 2 + 1)) - span / 4);
    return f;
  endfunction

  function automatic frame_t make_frame(logic c, int lx, int ly, int rx, int ry, int ny,
                                        int mlx, int mrx, int flx, int frx);
    frame_t f;
    f.complete = c;
    f.lx = lx[15:0]; f.ly = ly[15:0]; f.rx = rx[15:0]; f.ry = ry[15:0];
    f.ny = ny[15:0]; f.mlx = mlx[15:0]; f.mrx = mrx[15:0];
    f.flx = flx[15:0]; f.frx = frx[15:0];
    return f;
  endfunction

  initial begin
    int unsigned thr_set[6] = '{1638, 0, 16384, 200, 5000, 800};
    int unsigned rat_set[6] = '{13107, 1, 16384, 8000, 13107, 20};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames at reset settings: degenerate and saturating cases
    add_frame(make_frame(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));  // zero eye distance
    add_frame(make_frame(1, 65535, 65535, 65535, 65535, 65535, 65535,
                         65535, 65535, 65535));
    add_frame(make_frame(0, 1000, 2000, 3000, 2000, 5000, 1500, 2500,
                         500, 3500));                    // incomplete
    add_frame(make_frame(1, 0, 65535, 65535, 0, 65535, 65535, 65535, 0, 0));
    add_frame(make_frame(1, 0, 0, 65535, 65535, 0, 0, 0, 65535, 65535));
    add_frame(make_frame(1, 100, 0, 100, 65535, 0, 0, 0, 0, 0));  // yaw limit
    add_frame(make_frame(1, 100, 65535, 100, 0, 65535, 0, 0, 0, 0));
    add_frame(make_frame(1, 1000, 1000, 1001, 1000, 65535, 65535, 65535,
                         0, 0));                         // pitch and roll high
    add_frame(make_frame(1, 1000, 1000, 1001, 1000, 0, 0, 0, 65535, 65535));
    add_frame(make_frame(1, 20000, 30000, 21600, 30000, 31280, 20200, 21400,
                         19000, 22600));                 // level face
    add_frame(make_frame(0, 65535, 65535, 0, 0, 65535, 0, 65535, 0, 65535));
    add_frame(make_frame(1, 20000, 30000, 21600, 30000, 31280, 20200, 21400,
                         19000, 22600));
    add_frame(make_frame(1, 5, 5, 5, 5, 9, 1, 2, 3, 4));   // zero distance again
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      int unsigned thr, rat;
      thr = thr_set[ph];
      rat = rat_set[ph];
      if (ph == 3) begin
        thr = $urandom_range(0, 16384);
        rat = $urandom_range(1, 16384);
      end
      write_reg(CFG_MOVE_THR, thr);
      write_reg(CFG_NOSE_RATIO, rat);
      for (int n = 0; n < 305; n++)
        add_frame(($urandom_range(0, 4) == 0) ? odd_frame() : face_frame());
      // hold the output off while the sender keeps offering
      if (ph == 1) long_hold_req = 1'b1;
      drain();
    end

    if (mismatches == 0 && poses_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
